// File: hw/rtl/chtd_pkg.sv
// chtd_pkg: shared types for the convex hull trick dp core
// holds the datapath command codes and the status bundle; no dependencies
package chtd_pkg;

  localparam int unsigned SLOPE_W = 32;
  localparam int unsigned ICPT_W  = 64;
  localparam int unsigned LINE_W  = SLOPE_W + ICPT_W;
  localparam int unsigned PROD_W  = 66;
  localparam int unsigned WIDE_W  = 100;

  typedef enum logic [5:0] {
    OP_NOP, OP_LOAD,
    OP_Q_INIT, OP_Q_RD0, OP_Q_RD1, OP_Q_CAP, OP_Q_MUL, OP_Q_STEP,
    OP_V_RD, OP_V_CAP, OP_V_M1, OP_V_A1, OP_V_ZERO, OP_V_M2, OP_V_A2, OP_EMIT,
    OP_F_INIT, OP_F_RD, OP_F_CMP,
    OP_S_INIT, OP_S_RD, OP_S_WR, OP_S_PUT,
    OP_DI_P, OP_DI_N, OP_DI_V,
    OP_D_RDA, OP_D_RDB, OP_D_RDC, OP_D_CAPC,
    OP_D_M1, OP_D_M2, OP_D_M3, OP_D_M4, OP_D_M5,
    OP_R_INIT, OP_R_RD, OP_R_WR, OP_R_DEC, OP_R_DECP
  } chtd_op_e;

  typedef struct packed {
    logic empty;
    logic full;
    logic lo_lt_hi;
    logic idx_lt_cnt;
    logic rd_le;
    logic k_gt_p;
    logic k1_lt_cnt;
    logic p1_lt_cnt;
    logic p_gt0;
    logic dom;
  } chtd_status_t;

endpackage

// File: hw/rtl/chtd_ram.sv
// chtd_ram: generic single write, single read ram with registered read data
// no dependencies
module chtd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hw/rtl/chtd_datapath.sv
// chtd_datapath: hull storage, index registers, shared multiplier and compares
// depends on chtd_pkg and chtd_ram; driven one command per cycle by chtd_ctrl
module chtd_datapath #(
  parameter int unsigned MAX_LINES = 1024
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  chtd_pkg::chtd_op_e      op_i,
  input  logic signed [31:0]      position_i,
  input  logic signed [31:0]      cost_i,
  input  logic                    start_req_i,
  output chtd_pkg::chtd_status_t  status_o,
  output logic signed [63:0]      value_o,
  output logic                    value_valid_o
);

  localparam int unsigned AW = $clog2(MAX_LINES);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned PW = chtd_pkg::PROD_W;
  localparam int unsigned WW = chtd_pkg::WIDE_W;

  logic signed [31:0] x_q, c_q;
  logic        [63:0] v_q;
  logic [CW-1:0] cnt_q, lo_q, hi_q, idx_q, k_q, p_q, di_q;
  logic signed [31:0] sa_q, sb_q, sc_q;
  logic signed [63:0] ba_q, bb_q, bc_q;
  logic signed [PW-1:0] prod_q;
  logic signed [WW-1:0] lacc_q, racc_q;
  logic        [63:0] out_q;
  logic               outv_q;

  logic signed [32:0] mul_a, mul_b;
  logic [CW-1:0] raddr_w, waddr_w, mid_w;
  logic [chtd_pkg::LINE_W-1:0] wdata_w, rdata_w;
  logic we_w;
  logic signed [31:0] rd_slope;
  logic signed [63:0] rd_icpt;
  logic signed [64:0] dl_w, dr_w, dq_w;
  logic signed [32:0] d2l_w, d2r_w, d2q_w;
  logic rd_le_w, dom_w;

  assign rd_slope = rdata_w[chtd_pkg::LINE_W-1:chtd_pkg::ICPT_W];
  assign rd_icpt  = rdata_w[chtd_pkg::ICPT_W-1:0];
  assign mid_w    = lo_q + ((hi_q - lo_q) >> 1);
  assign dl_w     = {ba_q[63], ba_q} - {bb_q[63], bb_q};
  assign dr_w     = {bb_q[63], bb_q} - {bc_q[63], bc_q};
  assign dq_w     = dr_w;
  assign d2l_w    = {sc_q[31], sc_q} - {sb_q[31], sb_q};
  assign d2r_w    = {sb_q[31], sb_q} - {sa_q[31], sa_q};
  assign d2q_w    = d2l_w;
  assign rd_le_w  = rd_slope <= x_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_i)
      chtd_pkg::OP_Q_MUL: begin
        mul_a = d2q_w;
        mul_b = {x_q[31], x_q};
      end
      chtd_pkg::OP_V_M1: begin
        mul_a = {sb_q[31], sb_q};
        mul_b = {x_q[31], x_q};
      end
      chtd_pkg::OP_V_M2: begin
        mul_a = {x_q[31], x_q};
        mul_b = {x_q[31], x_q};
      end
      chtd_pkg::OP_D_M1: begin
        mul_a = {1'b0, dl_w[31:0]};
        mul_b = d2l_w;
      end
      chtd_pkg::OP_D_M2: begin
        mul_a = dl_w[64:32];
        mul_b = d2l_w;
      end
      chtd_pkg::OP_D_M3: begin
        mul_a = {1'b0, dr_w[31:0]};
        mul_b = d2r_w;
      end
      chtd_pkg::OP_D_M4: begin
        mul_a = dr_w[64:32];
        mul_b = d2r_w;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    raddr_w = '0;
    waddr_w = '0;
    wdata_w = rdata_w;
    we_w    = 1'b0;
    case (op_i)
      chtd_pkg::OP_Q_RD0: raddr_w = mid_w;
      chtd_pkg::OP_Q_RD1: raddr_w = idx_q + CW'(1);
      chtd_pkg::OP_V_RD:  raddr_w = lo_q;
      chtd_pkg::OP_F_RD:  raddr_w = idx_q;
      chtd_pkg::OP_S_RD:  raddr_w = k_q - CW'(1);
      chtd_pkg::OP_R_RD:  raddr_w = k_q + CW'(1);
      chtd_pkg::OP_D_RDA: raddr_w = di_q - CW'(1);
      chtd_pkg::OP_D_RDB: raddr_w = di_q;
      chtd_pkg::OP_D_RDC: raddr_w = di_q + CW'(1);
      chtd_pkg::OP_S_WR: begin
        we_w    = 1'b1;
        waddr_w = k_q;
      end
      chtd_pkg::OP_R_WR: begin
        we_w    = 1'b1;
        waddr_w = k_q;
      end
      chtd_pkg::OP_S_PUT: begin
        we_w    = 1'b1;
        waddr_w = p_q;
        wdata_w = {x_q, v_q};
      end
      default: begin
        raddr_w = '0;
      end
    endcase
  end

  chtd_ram #(
    .WIDTH(chtd_pkg::LINE_W),
    .DEPTH(MAX_LINES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we_w),
    .waddr_i (waddr_w[AW-1:0]),
    .wdata_i (wdata_w),
    .raddr_i (raddr_w[AW-1:0]),
    .rdata_o (rdata_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      outv_q <= 1'b0;
    end else begin
      outv_q <= (op_i == chtd_pkg::OP_EMIT);
      case (op_i)
        chtd_pkg::OP_LOAD:   if (start_req_i) cnt_q <= '0;
        chtd_pkg::OP_S_PUT:  cnt_q <= cnt_q + CW'(1);
        chtd_pkg::OP_R_DEC:  cnt_q <= cnt_q - CW'(1);
        chtd_pkg::OP_R_DECP: cnt_q <= cnt_q - CW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (op_i == chtd_pkg::OP_EMIT) begin
      out_q <= v_q;
    end
    case (op_i)
      chtd_pkg::OP_LOAD: begin
        x_q <= position_i;
        c_q <= cost_i;
        v_q <= 64'd0 - 64'(cost_i);
      end
      chtd_pkg::OP_Q_INIT: begin
        lo_q <= '0;
        hi_q <= cnt_q - CW'(1);
      end
      chtd_pkg::OP_Q_RD0: idx_q <= mid_w;
      chtd_pkg::OP_Q_RD1: begin
        sb_q <= rd_slope;
        bb_q <= rd_icpt;
      end
      chtd_pkg::OP_Q_CAP: begin
        sc_q <= rd_slope;
        bc_q <= rd_icpt;
      end
      chtd_pkg::OP_Q_STEP: begin
        if (PW'(dq_w) < prod_q) lo_q <= idx_q + CW'(1);
        else hi_q <= idx_q;
      end
      chtd_pkg::OP_V_CAP: begin
        sb_q <= rd_slope;
        bb_q <= rd_icpt;
      end
      chtd_pkg::OP_V_A1:   v_q <= prod_q[63:0] + bb_q;
      chtd_pkg::OP_V_ZERO: v_q <= '0;
      chtd_pkg::OP_V_A2:   v_q <= v_q - prod_q[63:0] - 64'(c_q);
      chtd_pkg::OP_F_INIT: idx_q <= '0;
      chtd_pkg::OP_F_CMP:  if (rd_le_w) idx_q <= idx_q + CW'(1);
      chtd_pkg::OP_S_INIT: begin
        p_q <= idx_q;
        k_q <= cnt_q;
      end
      chtd_pkg::OP_S_WR: k_q <= k_q - CW'(1);
      chtd_pkg::OP_DI_P: di_q <= p_q;
      chtd_pkg::OP_DI_N: di_q <= p_q + CW'(1);
      chtd_pkg::OP_DI_V: di_q <= p_q - CW'(1);
      chtd_pkg::OP_D_RDB: begin
        sa_q <= rd_slope;
        ba_q <= rd_icpt;
      end
      chtd_pkg::OP_D_RDC: begin
        sb_q <= rd_slope;
        bb_q <= rd_icpt;
      end
      chtd_pkg::OP_D_CAPC: begin
        sc_q <= rd_slope;
        bc_q <= rd_icpt;
      end
      chtd_pkg::OP_D_M2: lacc_q <= WW'(prod_q);
      chtd_pkg::OP_D_M3: lacc_q <= lacc_q + (WW'(prod_q) <<< 32);
      chtd_pkg::OP_D_M4: racc_q <= WW'(prod_q);
      chtd_pkg::OP_D_M5: racc_q <= racc_q + (WW'(prod_q) <<< 32);
      chtd_pkg::OP_R_INIT: k_q <= di_q;
      chtd_pkg::OP_R_WR:   k_q <= k_q + CW'(1);
      chtd_pkg::OP_R_DECP: p_q <= p_q - CW'(1);
      default: begin
        x_q <= x_q;
      end
    endcase
  end

  // line i is dominated: equal-slope rules at the ends, intersection test inside
  always_comb begin
    if (di_q == '0) begin
      dom_w = (cnt_q > CW'(1)) && (sb_q == sc_q) && (bc_q >= bb_q);
    end else if ((di_q + CW'(1)) >= cnt_q) begin
      dom_w = (sb_q == sa_q) && (ba_q >= bb_q);
    end else begin
      dom_w = lacc_q >= racc_q;
    end
  end

  always_comb begin
    status_o.empty      = (cnt_q == '0);
    status_o.full       = (cnt_q == CW'(MAX_LINES));
    status_o.lo_lt_hi   = (lo_q < hi_q);
    status_o.idx_lt_cnt = (idx_q < cnt_q);
    status_o.rd_le      = rd_le_w;
    status_o.k_gt_p     = (k_q > p_q);
    status_o.k1_lt_cnt  = ((k_q + CW'(1)) < cnt_q);
    status_o.p1_lt_cnt  = ((p_q + CW'(1)) < cnt_q);
    status_o.p_gt0      = (p_q != '0);
    status_o.dom        = dom_w;
  end

  assign value_o       = out_q;
  assign value_valid_o = outv_q;

endmodule

// File: hw/rtl/chtd_ctrl.sv
// chtd_ctrl: sequencer for query, insert and prune of the line hull
// depends on chtd_pkg; issues one datapath command per cycle
module chtd_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   start_req_i,
  input  chtd_pkg::chtd_status_t status_i,
  output chtd_pkg::chtd_op_e     op_o,
  output logic                   busy_o
);

  localparam logic [5:0] ST_IDLE  = 6'd0,  ST_QINIT = 6'd1,  ST_QCHK  = 6'd2;
  localparam logic [5:0] ST_QRD0  = 6'd3,  ST_QRD1  = 6'd4,  ST_QCAP  = 6'd5;
  localparam logic [5:0] ST_QMUL  = 6'd6,  ST_QSTEP = 6'd7,  ST_VRD   = 6'd8;
  localparam logic [5:0] ST_VCAP  = 6'd9,  ST_VM1   = 6'd10, ST_VA1   = 6'd11;
  localparam logic [5:0] ST_VZERO = 6'd12, ST_VM2   = 6'd13, ST_VA2   = 6'd14;
  localparam logic [5:0] ST_EMIT  = 6'd15, ST_FINIT = 6'd16, ST_FCHK  = 6'd17;
  localparam logic [5:0] ST_FRD   = 6'd18, ST_FCMP  = 6'd19, ST_SINIT = 6'd20;
  localparam logic [5:0] ST_SCHK  = 6'd21, ST_SRD   = 6'd22, ST_SWR   = 6'd23;
  localparam logic [5:0] ST_SPUT  = 6'd24, ST_DSET  = 6'd25, ST_DRDA  = 6'd26;
  localparam logic [5:0] ST_DRDB  = 6'd27, ST_DRDC  = 6'd28, ST_DCAPC = 6'd29;
  localparam logic [5:0] ST_DM1   = 6'd30, ST_DM2   = 6'd31, ST_DM3   = 6'd32;
  localparam logic [5:0] ST_DM4   = 6'd33, ST_DM5   = 6'd34, ST_DEVAL = 6'd35;
  localparam logic [5:0] ST_PHCHK = 6'd36, ST_RINIT = 6'd37, ST_RCHK  = 6'd38;
  localparam logic [5:0] ST_RRD   = 6'd39, ST_RWR   = 6'd40, ST_RDEC  = 6'd41;

  localparam logic [1:0] PH_P = 2'd0, PH_N = 2'd1, PH_V = 2'd2;

  logic [5:0] state_q, state_d;
  logic [1:0] ph_q, ph_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ph_q    <= PH_P;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ph_d    = ph_q;
    op_o    = chtd_pkg::OP_NOP;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_o    = chtd_pkg::OP_LOAD;
          state_d = start_req_i ? ST_EMIT : ST_QINIT;
        end
      end
      ST_QINIT: begin
        op_o    = chtd_pkg::OP_Q_INIT;
        state_d = status_i.empty ? ST_VZERO : ST_QCHK;
      end
      ST_QCHK:  state_d = status_i.lo_lt_hi ? ST_QRD0 : ST_VRD;
      ST_QRD0: begin
        op_o    = chtd_pkg::OP_Q_RD0;
        state_d = ST_QRD1;
      end
      ST_QRD1: begin
        op_o    = chtd_pkg::OP_Q_RD1;
        state_d = ST_QCAP;
      end
      ST_QCAP: begin
        op_o    = chtd_pkg::OP_Q_CAP;
        state_d = ST_QMUL;
      end
      ST_QMUL: begin
        op_o    = chtd_pkg::OP_Q_MUL;
        state_d = ST_QSTEP;
      end
      ST_QSTEP: begin
        op_o    = chtd_pkg::OP_Q_STEP;
        state_d = ST_QCHK;
      end
      ST_VRD: begin
        op_o    = chtd_pkg::OP_V_RD;
        state_d = ST_VCAP;
      end
      ST_VCAP: begin
        op_o    = chtd_pkg::OP_V_CAP;
        state_d = ST_VM1;
      end
      ST_VM1: begin
        op_o    = chtd_pkg::OP_V_M1;
        state_d = ST_VA1;
      end
      ST_VA1: begin
        op_o    = chtd_pkg::OP_V_A1;
        state_d = ST_VM2;
      end
      ST_VZERO: begin
        op_o    = chtd_pkg::OP_V_ZERO;
        state_d = ST_VM2;
      end
      ST_VM2: begin
        op_o    = chtd_pkg::OP_V_M2;
        state_d = ST_VA2;
      end
      ST_VA2: begin
        op_o    = chtd_pkg::OP_V_A2;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        op_o    = chtd_pkg::OP_EMIT;
        ph_d    = PH_P;
        state_d = status_i.full ? ST_IDLE : ST_FINIT;
      end
      ST_FINIT: begin
        op_o    = chtd_pkg::OP_F_INIT;
        state_d = ST_FCHK;
      end
      ST_FCHK:  state_d = status_i.idx_lt_cnt ? ST_FRD : ST_SINIT;
      ST_FRD: begin
        op_o    = chtd_pkg::OP_F_RD;
        state_d = ST_FCMP;
      end
      ST_FCMP: begin
        op_o    = chtd_pkg::OP_F_CMP;
        state_d = status_i.rd_le ? ST_FCHK : ST_SINIT;
      end
      ST_SINIT: begin
        op_o    = chtd_pkg::OP_S_INIT;
        state_d = ST_SCHK;
      end
      ST_SCHK:  state_d = status_i.k_gt_p ? ST_SRD : ST_SPUT;
      ST_SRD: begin
        op_o    = chtd_pkg::OP_S_RD;
        state_d = ST_SWR;
      end
      ST_SWR: begin
        op_o    = chtd_pkg::OP_S_WR;
        state_d = ST_SCHK;
      end
      ST_SPUT: begin
        op_o    = chtd_pkg::OP_S_PUT;
        state_d = ST_DSET;
      end
      ST_DSET: begin
        case (ph_q)
          PH_P:    op_o = chtd_pkg::OP_DI_P;
          PH_N:    op_o = chtd_pkg::OP_DI_N;
          default: op_o = chtd_pkg::OP_DI_V;
        endcase
        state_d = ST_DRDA;
      end
      ST_DRDA: begin
        op_o    = chtd_pkg::OP_D_RDA;
        state_d = ST_DRDB;
      end
      ST_DRDB: begin
        op_o    = chtd_pkg::OP_D_RDB;
        state_d = ST_DRDC;
      end
      ST_DRDC: begin
        op_o    = chtd_pkg::OP_D_RDC;
        state_d = ST_DCAPC;
      end
      ST_DCAPC: begin
        op_o    = chtd_pkg::OP_D_CAPC;
        state_d = ST_DM1;
      end
      ST_DM1: begin
        op_o    = chtd_pkg::OP_D_M1;
        state_d = ST_DM2;
      end
      ST_DM2: begin
        op_o    = chtd_pkg::OP_D_M2;
        state_d = ST_DM3;
      end
      ST_DM3: begin
        op_o    = chtd_pkg::OP_D_M3;
        state_d = ST_DM4;
      end
      ST_DM4: begin
        op_o    = chtd_pkg::OP_D_M4;
        state_d = ST_DM5;
      end
      ST_DM5: begin
        op_o    = chtd_pkg::OP_D_M5;
        state_d = ST_DEVAL;
      end
      ST_DEVAL: begin
        if (status_i.dom) begin
          state_d = ST_RINIT;
        end else begin
          case (ph_q)
            PH_P: begin
              ph_d    = PH_N;
              state_d = ST_PHCHK;
            end
            PH_N: begin
              ph_d    = PH_V;
              state_d = ST_PHCHK;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_PHCHK: begin
        if (ph_q == PH_N) begin
          if (status_i.p1_lt_cnt) state_d = ST_DSET;
          else ph_d = PH_V;
        end else begin
          state_d = status_i.p_gt0 ? ST_DSET : ST_IDLE;
        end
      end
      ST_RINIT: begin
        op_o    = chtd_pkg::OP_R_INIT;
        state_d = ST_RCHK;
      end
      ST_RCHK:  state_d = status_i.k1_lt_cnt ? ST_RRD : ST_RDEC;
      ST_RRD: begin
        op_o    = chtd_pkg::OP_R_RD;
        state_d = ST_RWR;
      end
      ST_RWR: begin
        op_o    = chtd_pkg::OP_R_WR;
        state_d = ST_RCHK;
      end
      ST_RDEC: begin
        op_o    = (ph_q == PH_V) ? chtd_pkg::OP_R_DECP : chtd_pkg::OP_R_DEC;
        state_d = (ph_q == PH_P) ? ST_IDLE : ST_PHCHK;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

// File: hw/rtl/convex_hull_trick_dp_core.sv
// convex_hull_trick_dp_core: top level of the dp step over an upper hull of lines
// depends on chtd_pkg, chtd_ctrl, chtd_datapath (which holds chtd_ram)
//
// A request is taken when start is high and busy is low. A start request clears
// the hull; every request yields one value on value_o, marked by a one-cycle
// value_valid_o that cannot be held off, and then, unless the hull is full,
// inserts its line and prunes. Each request runs its steps in order: the hull
// search and value, the slope scan, the shift on insert, the dominance tests and
// the shift on each removal, over the lines held (up to MAX_LINES). A start
// request skips the search and goes straight to its value. The single-port-read
// line memory and the shared 33x33 multiplier set this stepwise order.
module convex_hull_trick_dp_core #(
  parameter int unsigned MAX_LINES = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] position_i,
  input  logic signed [31:0] cost_i,
  input  logic               start_req_i,
  output logic signed [63:0] value_o,
  output logic               value_valid_o
);

  chtd_pkg::chtd_op_e     op;
  chtd_pkg::chtd_status_t status;

  chtd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .start_req_i (start_req_i),
    .status_i    (status),
    .op_o        (op),
    .busy_o      (busy)
  );

  chtd_datapath #(
    .MAX_LINES(MAX_LINES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .position_i    (position_i),
    .cost_i        (cost_i),
    .start_req_i   (start_req_i),
    .status_o      (status),
    .value_o       (value_o),
    .value_valid_o (value_valid_o)
  );

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("request taken without going busy");

  a_valid_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    value_valid_o |-> $past(busy)) else $error("result strobe while idle");

  a_start_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && start_req_i |=> ##1 value_valid_o)
    else $error("start request result late");

  a_never_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.full |-> !(op == chtd_pkg::OP_S_PUT)) else $error("insert into full hull");

endmodule

// File: tb/sv/convex_hull_trick_dp_checker.sv
// convex_hull_trick_dp_checker: watches requests and values of the dp core
// keeps its own line hull, predicts each value and compares; uses no package items
module convex_hull_trick_dp_checker #(
  parameter int unsigned MAX_LINES = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  logic signed [31:0] position_i,
  input  logic signed [31:0] cost_i,
  input  logic               start_req_i,
  input  logic signed [63:0] value_o,
  input  logic               value_valid_o,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [31:0] line_slope [MAX_LINES];
  logic signed [63:0] line_icpt [MAX_LINES];
  int                 line_cnt;
  logic signed [63:0] value_q [$];

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    errors++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
  endtask

  function automatic bit line_dominated(int i);
    logic signed [129:0] d1, d2, l, r;
    if (i == 0) begin
      if (line_cnt <= 1) return 0;
      return line_slope[0] == line_slope[1] && line_icpt[1] >= line_icpt[0];
    end
    if (i + 1 >= line_cnt)
      return line_slope[i] == line_slope[i-1] && line_icpt[i-1] >= line_icpt[i];
    d1 = line_icpt[i-1];
    d1 = d1 - line_icpt[i];
    d2 = line_slope[i+1];
    d2 = d2 - line_slope[i];
    l  = d1 * d2;
    d1 = line_icpt[i];
    d1 = d1 - line_icpt[i+1];
    d2 = line_slope[i];
    d2 = d2 - line_slope[i-1];
    r  = d1 * d2;
    return l >= r;
  endfunction

  function automatic void line_remove(int i);
    for (int k = i; k + 1 < line_cnt; k++) begin
      line_slope[k] = line_slope[k+1];
      line_icpt[k]  = line_icpt[k+1];
    end
    line_cnt--;
  endfunction

  function automatic void line_insert(logic signed [31:0] m, logic signed [63:0] b);
    int p;
    p = 0;
    if (line_cnt >= MAX_LINES) return;
    while (p < line_cnt && line_slope[p] <= m) p++;
    for (int k = line_cnt; k > p; k--) begin
      line_slope[k] = line_slope[k-1];
      line_icpt[k]  = line_icpt[k-1];
    end
    line_slope[p] = m;
    line_icpt[p]  = b;
    line_cnt++;
    if (line_dominated(p)) begin
      line_remove(p);
      return;
    end
    while (p + 1 < line_cnt && line_dominated(p + 1)) line_remove(p + 1);
    while (p > 0 && line_dominated(p - 1)) begin
      line_remove(p - 1);
      p--;
    end
  endfunction

  function automatic logic signed [63:0] hull_best(logic signed [31:0] x);
    int lo, hi, mid;
    logic signed [129:0] l, r, ds;
    logic signed [63:0] sx, sm;
    if (line_cnt == 0) return 0;
    lo = 0;
    hi = line_cnt - 1;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      l  = line_icpt[mid];
      l  = l - line_icpt[mid+1];
      ds = line_slope[mid+1];
      ds = ds - line_slope[mid];
      r  = ds * x;
      if (l < r) lo = mid + 1;
      else hi = mid;
    end
    sx = x;
    sm = line_slope[lo];
    return sm * sx + line_icpt[lo];
  endfunction

  function automatic logic signed [63:0] dp_value(logic signed [31:0] x,
                                                   logic signed [31:0] c, logic sr);
    logic signed [63:0] v, sx, sc;
    sx = x;
    sc = c;
    if (sr) begin
      line_cnt = 0;
      v = 64'sd0 - sc;
    end else begin
      v = hull_best(x) - sx * sx - sc;
    end
    line_insert(x, v);
    return v;
  endfunction

  assign pending = value_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [63:0] want;
    if (!rst_ni) begin
      line_cnt = 0;
      errors   = 0;
      value_q.delete();
    end else begin
      if (value_valid_o) begin
        if (value_q.size() == 0) begin
          report("unexpected value", value_o, '0);
        end else begin
          want = value_q.pop_front();
          if (value_o !== want) report("value", value_o, want);
        end
      end
      if (start && !busy) value_q = {value_q, dp_value(position_i, cost_i, start_req_i)};
    end
  end
endmodule

// File: tb/sv/convex_hull_trick_dp_core_test.sv
// convex_hull_trick_dp_core_test: top of the dp core regression
// drives directed and random requests; depends on the core and the checker
module convex_hull_trick_dp_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 20000000;

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               start = 0;
  logic               busy;
  logic signed [31:0] position_i = 0;
  logic signed [31:0] cost_i = 0;
  logic               start_req_i = 0;
  logic signed [63:0] value_o;
  logic               value_valid_o;
  int                 errors, pending, cycles = 0;
  bit                 quiet = 0;

  convex_hull_trick_dp_core DUT (.*);
  convex_hull_trick_dp_checker chk (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send(input logic [31:0] pos, input logic [31:0] cst, input logic sr);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk_i);
    end
    start       <= 1;
    position_i  <= pos;
    cost_i      <= cst;
    start_req_i <= sr;
    @(posedge clk_i iff !busy);
  endtask

  task automatic drain();
    start <= 0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic logic [31:0] rand_word(int small_chance);
    int r;
    r = $urandom_range(0, 99);
    if (r < small_chance) return $signed($urandom_range(0, 200)) - 100;
    if (r < small_chance + 5) return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
    return $urandom;
  endfunction

  initial begin
    int len;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // empty hull without a start request
    send(5, 3, 0);
    send(32'h80000000, 32'h7fffffff, 1);
    send(32'h7fffffff, 32'h80000000, 0);
    send(32'h80000000, 32'h80000000, 0);
    send(0, 0, 0);
    // equal slopes, lower then higher intercept
    send(10, 100, 1);
    send(10, 50, 0);
    send(10, 200, 0);
    send(10, -7, 0);
    send(3, 0, 0);
    send(-3, 0, 0);
    send(7, 1, 0);
    send(32'h7fffffff, 32'h7fffffff, 1);
    send(32'h7fffffff, 0, 0);
    send(-1, -1, 0);
    send(1, 1, 0);
    send(0, 0, 0);
    drain();
    for (int run = 0; run < 90; run++) begin
      if ($urandom_range(0, 9) == 0) quiet = ~quiet;
      len = (run % 30 == 29) ? $urandom_range(100, 200) : $urandom_range(1, 20);
      send(rand_word(50), rand_word(50), $urandom_range(0, 19) != 0);
      for (int k = 1; k < len; k++) begin
        if (k == len - 1) send(0, 0, 0);
        else send(rand_word(60), rand_word(60), $urandom_range(0, 49) == 0);
      end
      if (run % 25 == 12) drain();
    end
    drain();
    quiet = 0;
    do @(posedge clk_i); while (busy);
    repeat (50) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
